>>> hw/rtl/dsbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsbp_pkg
// shared types, constants and helpers of the desaturate blend pixel placer
// ----------------------------------------------------------------------------
package dsbp_pkg;

    // field widths
    localparam int unsigned CH_W        = 8;
    localparam int unsigned COORD_W     = 12;
    localparam int unsigned SIDE_W      = 13;
    localparam int unsigned PROG_W      = 7;
    localparam int unsigned OFFS_W      = 26;
    localparam int unsigned POS_W       = 14;   // signed placed coordinate
    localparam int unsigned NUM_W       = 15;   // products and gray numerator

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 13;

    // limits
    localparam int unsigned MAX_SIDE    = 4096;
    localparam int unsigned PROG_MAX    = 100;

    // luma weights in percent, plus rounding
    localparam int unsigned GRAY_WR     = 30;
    localparam int unsigned GRAY_WG     = 59;
    localparam int unsigned GRAY_WB     = 11;
    localparam int unsigned GRAY_ROUND  = 50;

    // floor(n/100) = (n * 5243) >> 19, exact for n below 43690
    localparam int unsigned RECIP100     = 5243;
    localparam int unsigned RECIP_SHIFT  = 19;
    localparam int unsigned RECIP_PROD_W = 28;

    // register reset values
    localparam int unsigned RST_PROGRESS = 100;
    localparam int unsigned RST_SCREEN_W = 1024;
    localparam int unsigned RST_SCREEN_H = 768;
    localparam int unsigned RST_ICON_W   = 256;
    localparam int unsigned RST_ICON_H   = 256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLEND_PROGRESS = 3'd0,
        REG_SCREEN_WIDTH   = 3'd1,
        REG_SCREEN_HEIGHT  = 3'd2,
        REG_ICON_WIDTH     = 3'd3,
        REG_ICON_HEIGHT    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0]    in_red;
        logic [CH_W-1:0]    in_green;
        logic [CH_W-1:0]    in_blue;
        logic [COORD_W-1:0] icon_col;
        logic [COORD_W-1:0] icon_row;
    } pixel_t;

    typedef struct packed {
        logic [OFFS_W-1:0] byte_offset;
        logic [CH_W-1:0]   out_blue;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_red;
        logic              on_screen;
    } place_t;

    // settings after saturation
    typedef struct packed {
        logic [PROG_W-1:0] blend_progress;
        logic [SIDE_W-1:0] screen_width;
        logic [SIDE_W-1:0] screen_height;
        logic [SIDE_W-1:0] icon_width;
        logic [SIDE_W-1:0] icon_height;
    } cfg_t;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_load_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } color_t;

    function automatic logic [CH_W-1:0] div100(input logic [NUM_W-1:0] n);
        logic [RECIP_PROD_W-1:0] prod;
        prod = RECIP_PROD_W'(n) * RECIP_PROD_W'(RECIP100);
        return CH_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

>>> hw/rtl/dsbp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsbp_cfg
// configuration registers with saturation of progress and sides
// ----------------------------------------------------------------------------
module dsbp_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dsbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dsbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dsbp_pkg::cfg_t                      cfg
);

    logic [dsbp_pkg::PROG_W-1:0] progress_reg, progress_next;
    logic [dsbp_pkg::SIDE_W-1:0] screen_w_reg, screen_w_next;
    logic [dsbp_pkg::SIDE_W-1:0] screen_h_reg, screen_h_next;
    logic [dsbp_pkg::SIDE_W-1:0] icon_w_reg, icon_w_next;
    logic [dsbp_pkg::SIDE_W-1:0] icon_h_reg, icon_h_next;

    function automatic logic [dsbp_pkg::SIDE_W-1:0] clamp_side(
        input logic [dsbp_pkg::SIDE_W-1:0] v);
        return (32'(v) > dsbp_pkg::MAX_SIDE) ? dsbp_pkg::SIDE_W'(dsbp_pkg::MAX_SIDE) : v;
    endfunction

    always_comb
    begin
        progress_next = progress_reg;
        screen_w_next = screen_w_reg;
        screen_h_next = screen_h_reg;
        icon_w_next   = icon_w_reg;
        icon_h_next   = icon_h_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dsbp_pkg::REG_BLEND_PROGRESS: progress_next = cfg_data[dsbp_pkg::PROG_W-1:0];
                dsbp_pkg::REG_SCREEN_WIDTH:   screen_w_next = cfg_data;
                dsbp_pkg::REG_SCREEN_HEIGHT:  screen_h_next = cfg_data;
                dsbp_pkg::REG_ICON_WIDTH:     icon_w_next   = cfg_data;
                dsbp_pkg::REG_ICON_HEIGHT:    icon_h_next   = cfg_data;
                default:                      ;  // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= dsbp_pkg::PROG_W'(dsbp_pkg::RST_PROGRESS);
            screen_w_reg <= dsbp_pkg::SIDE_W'(dsbp_pkg::RST_SCREEN_W);
            screen_h_reg <= dsbp_pkg::SIDE_W'(dsbp_pkg::RST_SCREEN_H);
            icon_w_reg   <= dsbp_pkg::SIDE_W'(dsbp_pkg::RST_ICON_W);
            icon_h_reg   <= dsbp_pkg::SIDE_W'(dsbp_pkg::RST_ICON_H);
        end
        else
        begin
            progress_reg <= progress_next;
            screen_w_reg <= screen_w_next;
            screen_h_reg <= screen_h_next;
            icon_w_reg   <= icon_w_next;
            icon_h_reg   <= icon_h_next;
        end
    end

    always_comb
    begin
        cfg.blend_progress = (32'(progress_reg) > dsbp_pkg::PROG_MAX)
                           ? dsbp_pkg::PROG_W'(dsbp_pkg::PROG_MAX) : progress_reg;
        cfg.screen_width   = clamp_side(screen_w_reg);
        cfg.screen_height  = clamp_side(screen_h_reg);
        cfg.icon_width     = clamp_side(icon_w_reg);
        cfg.icon_height    = clamp_side(icon_h_reg);
    end

endmodule

>>> hw/rtl/dsbp_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsbp_color
// four-stage color path: luma gray, then blend of each channel with gray
// ----------------------------------------------------------------------------
module dsbp_color
(
    input  logic                            clk,
    input  dsbp_pkg::pixel_t                pixel,
    input  logic [dsbp_pkg::PROG_W-1:0]     progress,
    input  dsbp_pkg::stage_load_t           load,
    output dsbp_pkg::color_t                color
);

    // stage 1: gray numerator and c*p products
    logic [dsbp_pkg::NUM_W-1:0] num_reg, num_next;
    logic [dsbp_pkg::NUM_W-1:0] cp_r_reg, cp_r_next;
    logic [dsbp_pkg::NUM_W-1:0] cp_g_reg, cp_g_next;
    logic [dsbp_pkg::NUM_W-1:0] cp_b_reg, cp_b_next;
    // stage 2: gray and c*p/100
    logic [dsbp_pkg::CH_W-1:0]  gray_reg, gray_next;
    logic [dsbp_pkg::CH_W-1:0]  q2_r_reg, q2_r_next;
    logic [dsbp_pkg::CH_W-1:0]  q2_g_reg, q2_g_next;
    logic [dsbp_pkg::CH_W-1:0]  q2_b_reg, q2_b_next;
    // stage 3: gray*(100-p)
    logic [dsbp_pkg::NUM_W-1:0] gn_reg, gn_next;
    logic [dsbp_pkg::CH_W-1:0]  q3_r_reg, q3_r_next;
    logic [dsbp_pkg::CH_W-1:0]  q3_g_reg, q3_g_next;
    logic [dsbp_pkg::CH_W-1:0]  q3_b_reg, q3_b_next;
    // stage 4: blended bytes
    dsbp_pkg::color_t           color_reg, color_next;

    logic [dsbp_pkg::CH_W-1:0]  gray_part;

    always_comb
    begin
        num_next  = dsbp_pkg::NUM_W'(pixel.in_red)   * dsbp_pkg::NUM_W'(dsbp_pkg::GRAY_WR)
                  + dsbp_pkg::NUM_W'(pixel.in_green) * dsbp_pkg::NUM_W'(dsbp_pkg::GRAY_WG)
                  + dsbp_pkg::NUM_W'(pixel.in_blue)  * dsbp_pkg::NUM_W'(dsbp_pkg::GRAY_WB)
                  + dsbp_pkg::NUM_W'(dsbp_pkg::GRAY_ROUND);
        cp_r_next = dsbp_pkg::NUM_W'(pixel.in_red)   * dsbp_pkg::NUM_W'(progress);
        cp_g_next = dsbp_pkg::NUM_W'(pixel.in_green) * dsbp_pkg::NUM_W'(progress);
        cp_b_next = dsbp_pkg::NUM_W'(pixel.in_blue)  * dsbp_pkg::NUM_W'(progress);

        gray_next = dsbp_pkg::div100(num_reg);
        q2_r_next = dsbp_pkg::div100(cp_r_reg);
        q2_g_next = dsbp_pkg::div100(cp_g_reg);
        q2_b_next = dsbp_pkg::div100(cp_b_reg);

        gn_next   = dsbp_pkg::NUM_W'(gray_reg)
                  * (dsbp_pkg::NUM_W'(dsbp_pkg::PROG_MAX) - dsbp_pkg::NUM_W'(progress));
        q3_r_next = q2_r_reg;
        q3_g_next = q2_g_reg;
        q3_b_next = q2_b_reg;

        // each term truncated on its own, sum wraps to a byte
        gray_part        = dsbp_pkg::div100(gn_reg);
        color_next.red   = q3_r_reg + gray_part;
        color_next.green = q3_g_reg + gray_part;
        color_next.blue  = q3_b_reg + gray_part;
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            num_reg  <= num_next;
            cp_r_reg <= cp_r_next;
            cp_g_reg <= cp_g_next;
            cp_b_reg <= cp_b_next;
        end
        if (load.s2)
        begin
            gray_reg <= gray_next;
            q2_r_reg <= q2_r_next;
            q2_g_reg <= q2_g_next;
            q2_b_reg <= q2_b_next;
        end
        if (load.s3)
        begin
            gn_reg   <= gn_next;
            q3_r_reg <= q3_r_next;
            q3_g_reg <= q3_g_next;
            q3_b_reg <= q3_b_next;
        end
        if (load.s4)
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

>>> hw/rtl/dsbp_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsbp_place
// four-stage placement path: centering, bounds check and byte offset
// ----------------------------------------------------------------------------
module dsbp_place
(
    input  logic                                clk,
    input  dsbp_pkg::pixel_t                    pixel,
    input  dsbp_pkg::cfg_t                      cfg,
    input  dsbp_pkg::stage_load_t               load,
    output logic [dsbp_pkg::OFFS_W-1:0]         byte_offset,
    output logic                                on_screen
);

    localparam int unsigned HALF_W = dsbp_pkg::SIDE_W - 1;

    // stage 1: placed position
    logic signed [dsbp_pkg::POS_W-1:0]  x1_reg, x1_next;
    logic signed [dsbp_pkg::POS_W-1:0]  y1_reg, y1_next;
    logic                               in_icon_reg, in_icon_next;
    // stage 2: row base and inside flag
    logic [dsbp_pkg::OFFS_W-1:0]        row_base_reg, row_base_next;
    logic [dsbp_pkg::SIDE_W-1:0]        x2_reg, x2_next;
    logic                               inside2_reg, inside2_next;
    // stage 3: byte offset
    logic [dsbp_pkg::OFFS_W-1:0]        offs3_reg, offs3_next;
    logic                               inside3_reg, inside3_next;
    // stage 4: output
    logic [dsbp_pkg::OFFS_W-1:0]        offs4_reg, offs4_next;
    logic                               inside4_reg, inside4_next;

    logic signed [dsbp_pkg::POS_W-1:0]  off_x, off_y;
    logic [dsbp_pkg::OFFS_W-1:0]        pix_index;

    always_comb
    begin
        // offset = screen/2 - icon/2, may go negative
        off_x = $signed(dsbp_pkg::POS_W'(cfg.screen_width[dsbp_pkg::SIDE_W-1:1]))
              - $signed(dsbp_pkg::POS_W'(cfg.icon_width[dsbp_pkg::SIDE_W-1:1]));
        off_y = $signed(dsbp_pkg::POS_W'(cfg.screen_height[dsbp_pkg::SIDE_W-1:1]))
              - $signed(dsbp_pkg::POS_W'(cfg.icon_height[dsbp_pkg::SIDE_W-1:1]));
        x1_next = $signed(dsbp_pkg::POS_W'(pixel.icon_col)) + off_x;
        y1_next = $signed(dsbp_pkg::POS_W'(pixel.icon_row)) + off_y;
        in_icon_next = (dsbp_pkg::SIDE_W'(pixel.icon_col) < cfg.icon_width)
                    && (dsbp_pkg::SIDE_W'(pixel.icon_row) < cfg.icon_height);

        inside2_next = in_icon_reg
                    && !x1_reg[dsbp_pkg::POS_W-1]
                    && (x1_reg[dsbp_pkg::SIDE_W-1:0] < cfg.screen_width)
                    && !y1_reg[dsbp_pkg::POS_W-1]
                    && (y1_reg[dsbp_pkg::SIDE_W-1:0] < cfg.screen_height);
        row_base_next = dsbp_pkg::OFFS_W'(dsbp_pkg::OFFS_W'(y1_reg[dsbp_pkg::SIDE_W-1:0])
                                          * dsbp_pkg::OFFS_W'(cfg.screen_width));
        x2_next       = x1_reg[dsbp_pkg::SIDE_W-1:0];

        // three bytes per pixel, zero when off screen
        pix_index    = row_base_reg + dsbp_pkg::OFFS_W'(x2_reg);
        offs3_next   = inside2_reg ? (pix_index + (pix_index << 1)) : '0;
        inside3_next = inside2_reg;

        offs4_next   = offs3_reg;
        inside4_next = inside3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            x1_reg      <= x1_next;
            y1_reg      <= y1_next;
            in_icon_reg <= in_icon_next;
        end
        if (load.s2)
        begin
            row_base_reg <= row_base_next;
            x2_reg       <= x2_next;
            inside2_reg  <= inside2_next;
        end
        if (load.s3)
        begin
            offs3_reg   <= offs3_next;
            inside3_reg <= inside3_next;
        end
        if (load.s4)
        begin
            offs4_reg   <= offs4_next;
            inside4_reg <= inside4_next;
        end
    end

    assign byte_offset = offs4_reg;
    assign on_screen   = inside4_reg;

    // half-side width must cover the placed coordinate range
    if (HALF_W + 2 > dsbp_pkg::POS_W)
    begin : g_bad_width
        $error("placed coordinate too narrow");
    end

endmodule

>>> hw/rtl/desaturate_blend_pixel_placer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desaturate_blend_pixel_placer_unit
// desaturating blend of one RGB888 icon pixel, centered into a framebuffer
// ----------------------------------------------------------------------------
// Takes one icon pixel per transaction (red, green, blue with its column and
// row in the icon) and returns one transaction with the framebuffer byte
// offset of its blue byte (three bytes per pixel) and the blended bytes in
// blue, green, red order. Gray is (30R+59G+11B+50)/100; each channel becomes
// c*p/100 + gray*(100-p)/100 with p the progress setting clamped to 100. The
// icon is centered with offset screen/2 - icon/2 per axis; sides above 4096
// are clamped. Pixels outside the icon or the screen come out with on_screen
// low and offset zero, colors still blended. The unit takes a new pixel every
// clock while the input is not stalled; it has four register stages, set by the
// two chained divide-by-100 reciprocal multiplies of the blend and by the
// row-times-width multiply of the address. Each stage loads
// whenever it is empty or the stage after it moves, so bubbles collapse and
// the input keeps flowing while a finished result waits on place_stall; the
// input stalls only when all four stages are full. Settings are written
// through cfg_write/cfg_index/cfg_data and must only change while no pixel is
// in flight; a write to an index past the register list is dropped.
// ----------------------------------------------------------------------------
module desaturate_blend_pixel_placer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [dsbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dsbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel in
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  dsbp_pkg::pixel_t                    pixel,
    // placed pixel out
    output logic                                place_valid,
    input  logic                                place_stall,
    output dsbp_pkg::place_t                    place
);

    dsbp_pkg::cfg_t         cfg;
    dsbp_pkg::stage_load_t  load;
    dsbp_pkg::color_t       color;
    logic [dsbp_pkg::OFFS_W-1:0] byte_offset;
    logic                   on_screen;

    // stage valid bits travel alongside the datapath registers
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;

    dsbp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        load.s4 = !s4_valid_reg || !place_stall;
        load.s3 = !s3_valid_reg || load.s4;
        load.s2 = !s2_valid_reg || load.s3;
        load.s1 = !s1_valid_reg || load.s2;

        s1_valid_next = load.s1 ? pixel_valid  : s1_valid_reg;
        s2_valid_next = load.s2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = load.s3 ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = load.s4 ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    dsbp_color u_color
    (
        .clk      (clk),
        .pixel    (pixel),
        .progress (cfg.blend_progress),
        .load     (load),
        .color    (color)
    );

    dsbp_place u_place
    (
        .clk         (clk),
        .pixel       (pixel),
        .cfg         (cfg),
        .load        (load),
        .byte_offset (byte_offset),
        .on_screen   (on_screen)
    );

    assign pixel_stall = !load.s1;
    assign place_valid = s4_valid_reg;

    always_comb
    begin
        place.byte_offset = byte_offset;
        place.out_blue    = color.blue;
        place.out_green   = color.green;
        place.out_red     = color.red;
        place.on_screen   = on_screen;
    end

`ifndef SYNTHESIS
    // input only stalls with every stage full and the output held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                         && s4_valid_reg && place_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted pixel lands in the first stage
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> s1_valid_reg)
        else $error("accepted transaction lost at stage 1");

    // a held output keeps the transaction behind it
    a_hold_keeps_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && place_stall && s3_valid_reg) |=> s3_valid_reg)
        else $error("stage 3 dropped while output held");

    // off-screen results carry a zero offset
    a_offscreen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (place_valid && !place.on_screen) |-> (place.byte_offset == '0))
        else $error("off-screen transaction with nonzero offset");
`endif

endmodule

>>> tb/desaturate_blend_pixel_placer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desaturate_blend_pixel_placer_unit_test
// self-checking bench for the desaturate blend pixel placer
// ----------------------------------------------------------------------------
// A driver process feeds pixels from a pending queue and a monitor process
// checks every placed pixel against a prediction made when its pixel was
// accepted. Settings are rewritten between phases while nothing is in flight,
// from the reset values through saturated, zero and off-screen placements to
// random ones. Both sides pause at random. In some phases neither side pauses,
// and in two of them the monitor holds off long enough to back up the unit.
// ----------------------------------------------------------------------------
module desaturate_blend_pixel_placer_unit_test;

    // first register index past the register list, writes there are dropped
    localparam logic [dsbp_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 3'd5;
    localparam int unsigned            PHASES           = 15;
    localparam int unsigned            PHASE_PIXELS     = 102;
    localparam int unsigned            LONG_HOLD        = 60;
    localparam int unsigned            DRAIN_CYCLES     = 8;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   cfg_write = 1'b0;
    logic [dsbp_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [dsbp_pkg::CFG_DATA_W-1:0]        cfg_data = '0;
    logic                                   pixel_valid = 1'b0;
    logic                                   pixel_stall;
    dsbp_pkg::pixel_t                       pixel = '0;
    logic                                   place_valid;
    logic                                   place_stall = 1'b0;
    dsbp_pkg::place_t                       place;

    // bench copy of the settings, raw as written
    logic [dsbp_pkg::PROG_W-1:0] set_progress = dsbp_pkg::PROG_W'(dsbp_pkg::RST_PROGRESS);
    logic [dsbp_pkg::SIDE_W-1:0] set_screen_w = dsbp_pkg::SIDE_W'(dsbp_pkg::RST_SCREEN_W);
    logic [dsbp_pkg::SIDE_W-1:0] set_screen_h = dsbp_pkg::SIDE_W'(dsbp_pkg::RST_SCREEN_H);
    logic [dsbp_pkg::SIDE_W-1:0] set_icon_w   = dsbp_pkg::SIDE_W'(dsbp_pkg::RST_ICON_W);
    logic [dsbp_pkg::SIDE_W-1:0] set_icon_h   = dsbp_pkg::SIDE_W'(dsbp_pkg::RST_ICON_H);

    dsbp_pkg::pixel_t       pending_pixels[$];
    dsbp_pkg::place_t       expected_places[$];
    int unsigned            mismatches = 0;

    // pacing controls shared between the stimulus and the two channel processes
    bit                     steady_flow = 1'b0;
    bit                     long_hold_req = 1'b0;
    int unsigned            send_gap = 0;
    int unsigned            stall_left = 0;
    int unsigned            hold_left = 0;

    desaturate_blend_pixel_placer_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .place_valid (place_valid),
        .place_stall (place_stall),
        .place       (place)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // sides above the maximum count as the maximum
    function automatic int unsigned clamp_side(input logic [dsbp_pkg::SIDE_W-1:0] side);
        return (side > dsbp_pkg::MAX_SIDE) ? dsbp_pkg::MAX_SIDE : int'(side);
    endfunction

    // both terms of the blend are truncated on their own
    function automatic int unsigned blend_channel(input int unsigned c, input int unsigned gray,
                                                  input int unsigned p);
        return (c * p) / dsbp_pkg::PROG_MAX
             + (gray * (dsbp_pkg::PROG_MAX - p)) / dsbp_pkg::PROG_MAX;
    endfunction

    function automatic dsbp_pkg::place_t predict_place(input dsbp_pkg::pixel_t px);
        dsbp_pkg::place_t res;
        int unsigned p;
        int unsigned sw;
        int unsigned sh;
        int unsigned iw;
        int unsigned ih;
        int unsigned gray;
        int          x;
        int          y;
        bit          lands;
        p    = (set_progress > dsbp_pkg::PROG_MAX) ? dsbp_pkg::PROG_MAX : int'(set_progress);
        sw   = clamp_side(set_screen_w);
        sh   = clamp_side(set_screen_h);
        iw   = clamp_side(set_icon_w);
        ih   = clamp_side(set_icon_h);
        gray = (dsbp_pkg::GRAY_WR * 32'(px.in_red) + dsbp_pkg::GRAY_WG * 32'(px.in_green)
                + dsbp_pkg::GRAY_WB * 32'(px.in_blue) + dsbp_pkg::GRAY_ROUND)
               / dsbp_pkg::PROG_MAX;
        // centering offset may go negative when the icon is wider than the screen
        x = int'(px.icon_col) + (int'(sw / 2) - int'(iw / 2));
        y = int'(px.icon_row) + (int'(sh / 2) - int'(ih / 2));
        lands = 32'(px.icon_col) < iw && 32'(px.icon_row) < ih &&
                x >= 0 && x < int'(sw) && y >= 0 && y < int'(sh);
        res.byte_offset = lands ? dsbp_pkg::OFFS_W'((y * int'(sw) + x) * 3) : '0;
        res.out_blue    = dsbp_pkg::CH_W'(blend_channel(32'(px.in_blue), gray, p));
        res.out_green   = dsbp_pkg::CH_W'(blend_channel(32'(px.in_green), gray, p));
        res.out_red     = dsbp_pkg::CH_W'(blend_channel(32'(px.in_red), gray, p));
        res.on_screen   = lands;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------

    // mostly back to back, sometimes a short pause, rarely a long pause
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(40, 13);
    endfunction

    // extremes show up more often than a flat spread would give
    function automatic logic [dsbp_pkg::CH_W-1:0] random_channel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return dsbp_pkg::CH_W'($urandom());
    endfunction

    function automatic logic [dsbp_pkg::SIDE_W-1:0] random_side();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return dsbp_pkg::SIDE_W'($urandom_range((1 << dsbp_pkg::SIDE_W) - 1,
                                                    dsbp_pkg::MAX_SIDE + 1));
        if (roll < 50)
            return dsbp_pkg::SIDE_W'($urandom_range(64, 1));
        return dsbp_pkg::SIDE_W'($urandom_range(dsbp_pkg::MAX_SIDE, 1));
    endfunction

    // mostly positions inside the icon, the rest anywhere in the 12-bit range
    function automatic dsbp_pkg::pixel_t random_pixel();
        dsbp_pkg::pixel_t px;
        int unsigned iw;
        int unsigned ih;
        iw = clamp_side(set_icon_w);
        ih = clamp_side(set_icon_h);
        px.in_red   = random_channel();
        px.in_green = random_channel();
        px.in_blue  = random_channel();
        if (iw > 0 && $urandom_range(99) < 80)
            px.icon_col = dsbp_pkg::COORD_W'($urandom_range(iw - 1));
        else
            px.icon_col = dsbp_pkg::COORD_W'($urandom());
        if (ih > 0 && $urandom_range(99) < 80)
            px.icon_row = dsbp_pkg::COORD_W'($urandom_range(ih - 1));
        else
            px.icon_row = dsbp_pkg::COORD_W'($urandom());
        return px;
    endfunction

    function automatic dsbp_pkg::pixel_t make_pixel(input int unsigned r, input int unsigned g,
                                                    input int unsigned b, input int unsigned col,
                                                    input int unsigned row);
        dsbp_pkg::pixel_t px;
        px.in_red   = dsbp_pkg::CH_W'(r);
        px.in_green = dsbp_pkg::CH_W'(g);
        px.in_blue  = dsbp_pkg::CH_W'(b);
        px.icon_col = dsbp_pkg::COORD_W'(col);
        px.icon_row = dsbp_pkg::COORD_W'(row);
        return px;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // configuration and phase control
    // ------------------------------------------------------------------------

    // only called while nothing is in flight, so the bench copy can follow at once
    task automatic write_reg(input logic [dsbp_pkg::CFG_INDEX_W-1:0] index,
                             input logic [dsbp_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            dsbp_pkg::REG_BLEND_PROGRESS: set_progress = dsbp_pkg::PROG_W'(data);
            dsbp_pkg::REG_SCREEN_WIDTH:   set_screen_w = dsbp_pkg::SIDE_W'(data);
            dsbp_pkg::REG_SCREEN_HEIGHT:  set_screen_h = dsbp_pkg::SIDE_W'(data);
            dsbp_pkg::REG_ICON_WIDTH:     set_icon_w   = dsbp_pkg::SIDE_W'(data);
            dsbp_pkg::REG_ICON_HEIGHT:    set_icon_h   = dsbp_pkg::SIDE_W'(data);
            default: ;
        endcase
    endtask

    // progress goes out with random bits above its own width
    task automatic configure(input int unsigned p, input int unsigned sw, input int unsigned sh,
                             input int unsigned iw, input int unsigned ih);
        write_reg(dsbp_pkg::REG_BLEND_PROGRESS,
                  {(dsbp_pkg::CFG_DATA_W - dsbp_pkg::PROG_W)'($urandom()),
                   dsbp_pkg::PROG_W'(p)});
        write_reg(dsbp_pkg::REG_SCREEN_WIDTH, dsbp_pkg::CFG_DATA_W'(sw));
        write_reg(dsbp_pkg::REG_SCREEN_HEIGHT, dsbp_pkg::CFG_DATA_W'(sh));
        write_reg(dsbp_pkg::REG_ICON_WIDTH, dsbp_pkg::CFG_DATA_W'(iw));
        write_reg(dsbp_pkg::REG_ICON_HEIGHT, dsbp_pkg::CFG_DATA_W'(ih));
    endtask

    // sampled on the falling edge, away from the driver and monitor updates
    task automatic wait_idle();
        @(negedge clk);
        while (pending_pixels.size() != 0 || pixel_valid || expected_places.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // pixel driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
        end
        else
        begin
            // a transaction completes here, predict its placement now
            if (pixel_valid && !pixel_stall)
                expected_places.push_back(predict_place(pixel));
            // payload holds while stalled, otherwise the next pixel or a gap
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_gap > 0 && !steady_flow)
                begin
                    send_gap--;
                    pixel_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    pixel       <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                    send_gap    = pick_pause();
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // placement monitor and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            place_stall <= 1'b0;
        end
        else
        begin
            if (place_valid && !place_stall)
            begin
                if (expected_places.size() == 0)
                begin
                    $display("%0t ns: placed pixel with none expected, actual %h", $time, place);
                    mismatches++;
                end
                else
                begin
                    dsbp_pkg::place_t want;
                    want = expected_places.pop_front();
                    check_field("byte_offset", 32'(want.byte_offset), 32'(place.byte_offset));
                    check_field("out_blue", 32'(want.out_blue), 32'(place.out_blue));
                    check_field("out_green", 32'(want.out_green), 32'(place.out_green));
                    check_field("out_red", 32'(want.out_red), 32'(place.out_red));
                    check_field("on_screen", 32'(want.on_screen), 32'(place.on_screen));
                end
            end
            // a long hold backs the pipeline up until the input stalls
            if (hold_left == 0 && long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                place_stall <= 1'b1;
            end
            else if (steady_flow)
            begin
                place_stall <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && $urandom_range(99) < 25)
                    stall_left = pick_pause();
                if (stall_left > 0)
                begin
                    stall_left--;
                    place_stall <= 1'b1;
                end
                else
                begin
                    place_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed pixels against the reset settings: full color kept,
        // 1024x768 screen, 256x256 icon centered at column 384, row 256
        pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0));
        pending_pixels.push_back(make_pixel(255, 255, 255, 255, 255));
        pending_pixels.push_back(make_pixel(255, 0, 0, 255, 0));
        pending_pixels.push_back(make_pixel(0, 255, 0, 0, 255));
        pending_pixels.push_back(make_pixel(0, 0, 255, 128, 128));
        pending_pixels.push_back(make_pixel(170, 85, 170, 12'hAAA, 12'h555));
        pending_pixels.push_back(make_pixel(85, 170, 85, 12'h555, 12'hAAA));
        // just outside the icon on each axis, and the far corner of the range
        pending_pixels.push_back(make_pixel(10, 20, 30, 256, 0));
        pending_pixels.push_back(make_pixel(40, 50, 60, 0, 256));
        pending_pixels.push_back(make_pixel(255, 255, 255, 4095, 4095));
        wait_idle();

        // gray only, then one step of progress away from it
        configure(0, dsbp_pkg::MAX_SIDE, dsbp_pkg::MAX_SIDE, dsbp_pkg::MAX_SIDE,
                  dsbp_pkg::MAX_SIDE);
        pending_pixels.push_back(make_pixel(255, 0, 0, 0, 0));
        pending_pixels.push_back(make_pixel(0, 255, 0, 4095, 4095));
        pending_pixels.push_back(make_pixel(0, 0, 255, 2048, 0));
        pending_pixels.push_back(make_pixel(255, 255, 255, 0, 4095));
        wait_idle();
        write_reg(dsbp_pkg::REG_BLEND_PROGRESS, dsbp_pkg::CFG_DATA_W'(1));
        pending_pixels.push_back(make_pixel(255, 128, 1, 7, 9));
        wait_idle();

        for (int unsigned k = 0; k < PHASES; k++)
        begin
            case (k)
                // all sides at the maximum, no color kept
                0: configure(0, dsbp_pkg::MAX_SIDE, dsbp_pkg::MAX_SIDE, dsbp_pkg::MAX_SIDE,
                             dsbp_pkg::MAX_SIDE);
                // progress and sides past their limits saturate
                1: configure(127, 8191, 1, 8191, 1);
                // zero-width screen, nothing lands
                2: configure(100, 0, 768, 256, 256);
                3: configure(50, 1024, 768, 256, 256);
                // icon larger than the screen, negative centering offset
                4: configure(1, 100, 50, 300, 200);
                // zero-size icon on a zero-height screen
                5: configure(99, 64, 0, 0, 16);
                default: configure($urandom_range(127), random_side(), random_side(),
                                   random_side(), random_side());
            endcase
            // writes past the register list must leave the settings alone
            if (k == 4)
                for (int unsigned i = REG_FIRST_UNUSED; i < (1 << dsbp_pkg::CFG_INDEX_W); i++)
                    write_reg(dsbp_pkg::CFG_INDEX_W'(i), dsbp_pkg::CFG_DATA_W'($urandom()));
            steady_flow = (k % 4 == 3);
            if (k == 3 || k == 11)
                long_hold_req = 1'b1;
            for (int unsigned n = 0; n < PHASE_PIXELS; n++)
                pending_pixels.push_back(random_pixel());
            wait_idle();
            steady_flow = 1'b0;
        end

        // let any stray placement surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
